### design/stb_pkg.sv
// Shared types and constants for the sprite texel blitter.
// No dependencies; imported by every design module and the checker.
package stb_pkg;

    // Request codes
    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_BLIT  = 1'b1;

    // Configuration register indexes
    localparam int           CFG_IDX_W       = 2;
    localparam int           CFG_DATA_W      = 5;
    localparam logic [1:0]   CFG_PIXEL_SCALE = 2'd0;
    localparam logic [1:0]   CFG_TILE_TEXELS = 2'd1;
    localparam logic [1:0]   CFG_ROTATED     = 2'd2;

    // Clamp limits for scale and tile size
    localparam logic [3:0]   MAX_SCALE = 4'd8;
    localparam logic [4:0]   TILE_MAX  = 5'd16;

    // Signed screen coordinate width: covers -120 .. 382
    localparam int           COORD_W   = 11;
    // Block offset counter width
    localparam int           OFS_W     = 3;
    // Occupancy memory row geometry
    localparam int           ROW_W     = 64;
    localparam int           ROW_SEL_W = 6;

    typedef struct packed {
        logic       req_type;
        logic [7:0] origin_x;
        logic [6:0] origin_y;
        logic [3:0] texel_x;
        logic [3:0] texel_y;
        logic       texel_lit;
        logic [3:0] texel_color;
    } t_in_req;

    typedef struct packed {
        logic [14:0] pixel_index;
        logic [3:0]  color_index;
        logic        last;
    } t_out_pix;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mem_rd;
        logic mark;
        logic advance;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic req_clear;
        logic req_draw;
        logic in_range;
        logic occupied;
        logic last_pix;
        logic pend_valid;
        logic out_free;
    } t_dp_status;

endpackage

### design/stb_ctrl.sv
// Controller FSM for the sprite texel blitter: clear sweep, pixel walk, flush.
// Depends on stb_pkg; drives stb_datapath through t_dp_cmd.
module stb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stb_pkg::t_dp_status i_status,
    output stb_pkg::t_dp_cmd   o_cmd
);
    import stb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.req_clear) begin
                        n_state = ST_CLEAR;
                    end else if (i_status.req_draw) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (!i_status.in_range) begin
                    o_cmd.advance = 1'b1;
                    if (i_status.last_pix) n_state = ST_FLUSH;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.occupied) begin
                    o_cmd.advance = 1'b1;
                    n_state       = i_status.last_pix ? ST_FLUSH : ST_READ;
                end else if (!i_status.pend_valid || i_status.out_free) begin
                    o_cmd.mark    = 1'b1;
                    o_cmd.advance = 1'b1;
                    n_state       = i_status.last_pix ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### design/stb_datapath.sv
// Datapath of the sprite texel blitter: config registers, block walk counters,
// occupancy mask memory, pending pixel and output register. Depends on stb_pkg.
module stb_datapath #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stb_pkg::t_dp_cmd              i_cmd,
    output stb_pkg::t_dp_status           o_status,
    input  stb_pkg::t_in_req              i_in_data,
    input  logic                          i_cfg_valid,
    input  logic [stb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output stb_pkg::t_out_pix             o_out_data
);
    import stb_pkg::*;

    localparam int ROWS = (SCREEN_WIDTH * SCREEN_HEIGHT + ROW_W - 1) / ROW_W;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MAW  = RAW + ROW_SEL_W;
    localparam int PW   = (MAW > 15) ? MAW : 15;
    localparam int XCW  = $clog2(SCREEN_WIDTH + 1) + 1;
    localparam int YCW  = $clog2(SCREEN_HEIGHT + 1) + 1;
    localparam int CMPW = (XCW > COORD_W) ? ((XCW > YCW) ? XCW : YCW)
                        : ((COORD_W > YCW) ? COORD_W : YCW);
    localparam logic signed [CMPW-1:0] W_S = CMPW'(SCREEN_WIDTH);
    localparam logic signed [CMPW-1:0] H_S = CMPW'(SCREEN_HEIGHT);

    // configuration
    logic [3:0] r_cfg_scale;
    logic [4:0] r_cfg_tile;
    logic       r_cfg_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_scale <= 4'd1;
            r_cfg_tile  <= 5'd16;
            r_cfg_rot   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PIXEL_SCALE: r_cfg_scale <= i_cfg_data[3:0];
                CFG_TILE_TEXELS: r_cfg_tile  <= i_cfg_data[4:0];
                CFG_ROTATED:     r_cfg_rot   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [3:0] s_cl;
    logic [3:0] s_m1;
    logic [4:0] t_cl;

    always_comb begin
        if (r_cfg_scale == 4'd0)          s_cl = 4'd1;
        else if (r_cfg_scale > MAX_SCALE) s_cl = MAX_SCALE;
        else                              s_cl = r_cfg_scale;
        if (r_cfg_tile == 5'd0)           t_cl = 5'd1;
        else if (r_cfg_tile > TILE_MAX)   t_cl = TILE_MAX;
        else                              t_cl = r_cfg_tile;
    end
    assign s_m1 = s_cl - 4'd1;

    // texel base coordinates, computed at load
    logic [7:0]                s_tx;
    logic [7:0]                s_ty;
    logic signed [5:0]         mir_t;
    logic signed [COORD_W-1:0] mir_prod;
    logic signed [COORD_W-1:0] r_base_x;
    logic signed [COORD_W-1:0] r_base_y;
    logic signed [COORD_W-1:0] r_base_m;
    logic [3:0]                r_color;
    logic [OFS_W-1:0]          r_ox;
    logic [OFS_W-1:0]          r_oy;

    assign s_tx     = 8'(s_cl) * 8'(i_in_data.texel_x);
    assign s_ty     = 8'(s_cl) * 8'(i_in_data.texel_y);
    assign mir_t    = $signed({1'b0, t_cl}) - 6'sd1 - $signed({2'b00, i_in_data.texel_x});
    assign mir_prod = COORD_W'($signed({1'b0, s_cl})) * COORD_W'(mir_t);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base_x <= COORD_W'($signed({1'b0, i_in_data.origin_x}))
                      + COORD_W'($signed({1'b0, s_tx}));
            r_base_y <= COORD_W'($signed({1'b0, i_in_data.origin_y}))
                      + COORD_W'($signed({1'b0, s_ty}));
            r_base_m <= COORD_W'($signed({1'b0, i_in_data.origin_x})) + mir_prod;
            r_color  <= i_in_data.texel_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cmd.load) begin
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cmd.advance) begin
            if ({1'b0, r_oy} == s_m1) begin
                r_oy <= '0;
                r_ox <= r_ox + 1'b1;
            end else begin
                r_oy <= r_oy + 1'b1;
            end
        end
    end

    // current pixel
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] mx;
    logic signed [CMPW-1:0]    px_e;
    logic signed [CMPW-1:0]    py_e;
    logic signed [CMPW-1:0]    mx_e;
    logic                      in_range;
    logic [MAW-1:0]            bit_addr;
    logic [PW-1:0]             idx_row;
    logic [PW-1:0]             idx_rot;

    assign px   = r_base_x + COORD_W'($signed({1'b0, r_ox}));
    assign py   = r_base_y + COORD_W'($signed({1'b0, r_oy}));
    assign mx   = r_base_m + COORD_W'($signed({1'b0, r_ox}));
    assign px_e = CMPW'(px);
    assign py_e = CMPW'(py);
    assign mx_e = CMPW'(mx);

    assign in_range = (px_e >= 0) && (px_e < W_S) && (py_e >= 0) && (py_e < H_S)
                   && (!r_cfg_rot || ((mx_e >= 0) && (mx_e < W_S)));

    assign bit_addr = MAW'($unsigned(px)) * MAW'(SCREEN_HEIGHT) + MAW'($unsigned(py));
    assign idx_row  = PW'(SCREEN_WIDTH) * PW'($unsigned(py)) + PW'($unsigned(px));
    assign idx_rot  = PW'($unsigned(mx)) * PW'(SCREEN_HEIGHT) + PW'($unsigned(py));

    // occupancy mask memory
    logic [ROW_W-1:0]     r_mask_mem [ROWS];
    logic [ROW_W-1:0]     r_rd_row;
    logic [RAW-1:0]       r_row;
    logic [ROW_SEL_W-1:0] r_bit;
    logic [14:0]          r_idx;
    logic [RAW-1:0]       r_clr_ptr;
    logic                 clr_done;
    logic                 mem_we;
    logic [RAW-1:0]       mem_wa;
    logic [ROW_W-1:0]     mem_wd;

    assign clr_done = (r_clr_ptr == RAW'(ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_ptr <= clr_done ? '0 : r_clr_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_row <= bit_addr[MAW-1:ROW_SEL_W];
            r_bit <= bit_addr[ROW_SEL_W-1:0];
            r_idx <= r_cfg_rot ? idx_rot[14:0] : idx_row[14:0];
        end
    end

    assign mem_we = i_cmd.clr_step || i_cmd.mark;
    assign mem_wa = i_cmd.clr_step ? r_clr_ptr : r_row;
    assign mem_wd = i_cmd.clr_step ? '0 : (r_rd_row | (ROW_W'(1) << r_bit));

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mask_mem[mem_wa] <= mem_wd;
        if (i_cmd.mem_rd) r_rd_row <= r_mask_mem[bit_addr[MAW-1:ROW_SEL_W]];
    end

    // pending pixel and output register
    logic        r_pend_valid;
    logic [14:0] r_pend_idx;
    logic [3:0]  r_pend_color;
    logic        r_out_valid;
    t_out_pix    r_out;
    logic        out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.mark) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mark) begin
            r_pend_idx   <= r_idx;
            r_pend_color <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.mark && r_pend_valid) || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.mark && r_pend_valid) || i_cmd.flush) begin
            r_out.pixel_index <= r_pend_idx;
            r_out.color_index <= r_pend_color;
            r_out.last        <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_status            = '0;
        o_status.clr_done   = clr_done;
        o_status.req_clear  = (i_in_data.req_type == REQ_CLEAR);
        o_status.req_draw   = (i_in_data.req_type == REQ_BLIT) && i_in_data.texel_lit;
        o_status.in_range   = in_range;
        o_status.occupied   = r_rd_row[r_bit];
        o_status.last_pix   = ({1'b0, r_ox} == s_m1) && ({1'b0, r_oy} == s_m1);
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

endmodule

### design/sprite_texel_blitter.sv
// Sprite texel blitter top level: controller plus datapath.
// Depends on stb_pkg, stb_ctrl and stb_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request:
//   a clear of the occupancy mask, or one texel to blit. Output channel
//   (o_out_valid / i_out_stall / o_out_data) gives one framebuffer pixel per
//   request moved, with last set on the final pixel of a texel.
//   Config port (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; write it only while the block is idle.
// Timing:
//   After reset and after every clear request the mask memory is swept one
//   64-bit row per cycle, ceil(SCREEN_WIDTH*SCREEN_HEIGHT/64) rows (320 at
//   160x128); no requests are taken during the sweep.
//   An unlit texel is taken with no walk. A lit texel of scale s is loaded,
//   then walks s*s pixels: an off-screen one is skipped without a mask read,
//   an on-screen one gets a mask read, then a check and a write if it is free;
//   a flush ends the walk. Each emitted pixel waits in a pending register
//   until the next one is marked or the flush, so last can be set; the
//   output register lets a new request enter while a pixel waits. A stalled
//   receiver holds the output and pauses the walk.
module sprite_texel_blitter #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  stb_pkg::t_in_req              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output stb_pkg::t_out_pix             o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import stb_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    stb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    stb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### design/stb_checker.sv
// Port-level checker for sprite_texel_blitter, bound to the top level.
// Depends on stb_pkg.
module stb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input stb_pkg::t_in_req              i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input stb_pkg::t_out_pix             o_out_data
);
    import stb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output request dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output request changed under stall");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during reset clear sweep");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.req_type == REQ_CLEAR) |=> o_in_stall)
        else $error("clear request did not start a sweep");

    a_blit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.req_type == REQ_BLIT)
        && i_in_data.texel_lit |=> o_in_stall)
        else $error("lit texel request did not start a block walk");

endmodule

bind sprite_texel_blitter stb_checker u_stb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### sim/sprite_texel_blitter_tb.sv
// Self-checking testbench for sprite_texel_blitter: directed texel table, then randomized
// texel/clear traffic under several scale, tile and layout settings, with random stalls.
// Depends on stb_pkg and the sprite_texel_blitter design sources.
module sprite_texel_blitter_tb;
    import stb_pkg::*;

    localparam int SCREEN_W      = 160;
    localparam int SCREEN_H      = 128;
    localparam int SCREEN_PIXELS = SCREEN_W * SCREEN_H;
    localparam int SETTLE_CYCLES = 400;   // outlasts a full clear sweep or the longest texel walk
    localparam int NUM_DIR       = 14;
    localparam int NUM_PHASES    = 8;
    localparam int LIT_PER_PHASE = 12;

    typedef struct {
        t_in_req  req;
        int       n_typed;    // -1: use predictor, else number of typed pixels
        t_out_pix typed;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_req               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_pix              o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state
    bit         occ_map [SCREEN_PIXELS];
    logic [3:0] cfg_scale   = 4'd1;
    logic [4:0] cfg_tile    = 5'd16;
    logic       cfg_rotated = 1'b0;

    t_out_pix texel_pixels [$];
    t_out_pix pixels_due [$];
    t_out_pix due_pix;
    int       error_count  = 0;
    int       tx_idle_pct  = 0;
    int       rx_stall_pct = 0;

    t_dir_row dir_rows [NUM_DIR] = '{
        '{'{REQ_BLIT,  8'd0,   7'd0,   4'd0,  4'd0,  1'b1, 4'hF}, 1, '{15'd0,     4'hF, 1'b1}},
        '{'{REQ_BLIT,  8'd0,   7'd0,   4'd0,  4'd0,  1'b1, 4'hF}, 0, '0},
        '{'{REQ_BLIT,  8'd159, 7'd127, 4'd0,  4'd0,  1'b1, 4'h5}, 1, '{15'd20479, 4'h5, 1'b1}},
        '{'{REQ_BLIT,  8'd159, 7'd127, 4'd15, 4'd15, 1'b1, 4'h5}, 0, '0},
        '{'{REQ_BLIT,  8'd10,  7'd10,  4'd3,  4'd3,  1'b0, 4'h7}, 0, '0},
        '{'{REQ_CLEAR, 8'd159, 7'd127, 4'd15, 4'd15, 1'b1, 4'hF}, 0, '0},
        '{'{REQ_BLIT,  8'd0,   7'd0,   4'd0,  4'd0,  1'b1, 4'hA}, 1, '{15'd0,     4'hA, 1'b1}},
        '{'{REQ_BLIT,  8'd100, 7'd50,  4'd5,  4'd3,  1'b1, 4'h3}, 1, '{15'd8585,  4'h3, 1'b1}},
        '{'{REQ_BLIT,  8'd159, 7'd0,   4'd1,  4'd0,  1'b1, 4'h9}, 0, '0},
        '{'{REQ_BLIT,  8'd0,   7'd127, 4'd0,  4'd1,  1'b1, 4'h9}, 0, '0},
        '{'{REQ_BLIT,  8'd0,   7'd0,   4'd15, 4'd15, 1'b1, 4'h0}, 1, '{15'd2415,  4'h0, 1'b1}},
        '{'{REQ_BLIT,  8'd85,  7'd42,  4'd10, 4'd5,  1'b1, 4'h6}, -1, '0},
        '{'{REQ_BLIT,  8'd128, 7'd85,  4'd5,  4'd10, 1'b1, 4'hC}, -1, '0},
        '{'{REQ_BLIT,  8'd37,  7'd99,  4'd9,  4'd6,  1'b0, 4'h2}, 0, '0}
    };

    sprite_texel_blitter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Pixels a texel request produces; clear empties the mask.
    task automatic expand_texel(input t_in_req r);
        int s, tile, tx, ty, px, py, mx, ox, oy;
        t_out_pix pix;
        texel_pixels.delete();
        if (r.req_type == REQ_CLEAR) begin
            occ_map = '{default: 1'b0};
            return;
        end
        if (!r.texel_lit) return;
        s    = (cfg_scale == 0) ? 1 : (cfg_scale > MAX_SCALE) ? int'(MAX_SCALE) : int'(cfg_scale);
        tile = (cfg_tile == 0) ? 1 : (cfg_tile > TILE_MAX) ? int'(TILE_MAX) : int'(cfg_tile);
        tx   = int'(r.texel_x);
        ty   = int'(r.texel_y);
        for (ox = 0; ox < s; ox++) begin
            for (oy = 0; oy < s; oy++) begin
                px = ox + int'(r.origin_x) + s * tx;
                py = oy + int'(r.origin_y) + s * ty;
                mx = ox + int'(r.origin_x) + s * (tile - 1 - tx);
                if (px < 0 || px >= SCREEN_W || py < 0 || py >= SCREEN_H) continue;
                if (cfg_rotated && (mx < 0 || mx >= SCREEN_W)) continue;
                if (occ_map[px * SCREEN_H + py]) continue;
                occ_map[px * SCREEN_H + py] = 1'b1;
                pix.pixel_index = cfg_rotated ? 15'(mx * SCREEN_H + py) : 15'(SCREEN_W * py + px);
                pix.color_index = r.texel_color;
                pix.last        = 1'b0;
                texel_pixels.push_back(pix);
            end
        end
        if (texel_pixels.size() > 0) texel_pixels[texel_pixels.size() - 1].last = 1'b1;
    endtask

    // Starts and ends on a falling edge.
    task automatic send_req(input t_in_req r, input int n_typed, input t_out_pix typed);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        expand_texel(r);
        if (n_typed < 0) begin
            foreach (texel_pixels[k]) pixels_due.push_back(texel_pixels[k]);
        end else if (n_typed == 1) begin
            pixels_due.push_back(typed);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [4:0] scale, input logic [4:0] tile, input logic rot);
        logic [CFG_IDX_W-1:0]  idx  [3];
        logic [CFG_DATA_W-1:0] vals [3];
        int i;
        idx  = '{CFG_PIXEL_SCALE, CFG_TILE_TEXELS, CFG_ROTATED};
        vals = '{scale, tile, {4'd0, rot}};
        for (i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                CFG_PIXEL_SCALE: cfg_scale   = vals[i][3:0];
                CFG_TILE_TEXELS: cfg_tile    = vals[i][4:0];
                CFG_ROTATED:     cfg_rotated = vals[i][0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly runs of texels on one tile after a clear, with some noise mixed in.
    task automatic random_phase(input int n_lit);
        int lit_done, run_left, roll;
        logic [7:0] tile_x;
        logic [6:0] tile_y;
        t_in_req r;
        lit_done = 0;
        run_left = 0;
        tile_x   = '0;
        tile_y   = '0;
        r = '0;
        r.req_type = REQ_CLEAR;
        send_req(r, -1, '0);
        while (lit_done < n_lit) begin
            if (run_left == 0) begin
                if ($urandom_range(1)) begin
                    tile_x = 8'($urandom_range(40));
                    tile_y = 7'($urandom_range(30));
                end else begin
                    tile_x = 8'($urandom_range(SCREEN_W - 1));
                    tile_y = 7'($urandom_range(SCREEN_H - 1));
                end
                run_left = $urandom_range(8, 3);
            end
            run_left--;
            roll          = $urandom_range(99);
            r.origin_x    = tile_x;
            r.origin_y    = tile_y;
            r.texel_x     = 4'($urandom_range(15));
            r.texel_y     = 4'($urandom_range(15));
            r.texel_color = 4'($urandom_range(15));
            r.texel_lit   = ($urandom_range(99) < 85);
            r.req_type    = REQ_BLIT;
            if (roll < 8) begin
                r.req_type = REQ_CLEAR;
            end else if (roll < 20) begin
                r.req_type  = $urandom_range(1) ? REQ_BLIT : REQ_CLEAR;
                r.origin_x  = 8'($urandom_range(SCREEN_W - 1));
                r.origin_y  = 7'($urandom_range(SCREEN_H - 1));
                r.texel_lit = 1'($urandom_range(1));
            end
            send_req(r, -1, '0);
            if (r.req_type == REQ_BLIT && r.texel_lit) lit_done++;
            if ($urandom_range(29) == 0) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixels_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected pixel: index %0d color %0d last %0d",
                             o_out_data.pixel_index, o_out_data.color_index, o_out_data.last);
            end else begin
                due_pix = pixels_due.pop_front();
                if (o_out_data.pixel_index !== due_pix.pixel_index ||
                    o_out_data.color_index !== due_pix.color_index ||
                    o_out_data.last !== due_pix.last) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("pixel mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 due_pix.pixel_index, due_pix.color_index, due_pix.last,
                                 o_out_data.pixel_index, o_out_data.color_index,
                                 o_out_data.last);
                end
            end
        end
    end

    initial begin
        logic [4:0] phase_scale [NUM_PHASES];
        logic [4:0] phase_tile  [NUM_PHASES];
        logic       phase_rot   [NUM_PHASES];
        int p, k;
        phase_scale = '{5'd8,  5'd2, 5'd0, 5'd15, 5'd1,  5'd3, 5'd5,  5'd0};
        phase_tile  = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd16, 5'd1, 5'd20, 5'd0};
        phase_rot   = '{1'b0,  1'b1, 1'b1, 1'b0,  1'b1,  1'b0, 1'b1,  1'b0};
        phase_scale[NUM_PHASES - 1] = 5'($urandom_range(15));
        phase_tile[NUM_PHASES - 1]  = 5'($urandom_range(31));
        phase_rot[NUM_PHASES - 1]   = 1'($urandom_range(1));

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        tx_idle_pct  = 24;
        rx_stall_pct = 56;
        for (k = 0; k < NUM_DIR; k++) begin
            send_req(dir_rows[k].req, dir_rows[k].n_typed, dir_rows[k].typed);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p >= 6) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end else if (p >= 3) begin
                tx_idle_pct  = 56;
                rx_stall_pct = 24;
            end
            configure(phase_scale[p], phase_tile[p], phase_rot[p]);
            random_phase(LIT_PER_PHASE);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("sprite_texel_blitter regression: pass");
        end else begin
            $display("sprite_texel_blitter regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("sprite_texel_blitter regression: fail");
        $finish;
    end

endmodule

### files.f
design/stb_pkg.sv
design/stb_ctrl.sv
design/stb_datapath.sv
design/sprite_texel_blitter.sv
design/stb_checker.sv
sim/sprite_texel_blitter_tb.sv
